// ===== rtl/sfwd_pkg.sv =====
// Package: shared constants, types and codes of the scale frame weight decoder.
`default_nettype none

package sfwd_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 14;
  localparam int unsigned FIELD_CHARS = 7;
  localparam int unsigned FIELD_START = 2;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES + 1);

  // Payload widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ACC_W    = 24;
  localparam int unsigned WEIGHT_W = 25;
  localparam int unsigned FRAC_W   = 3;
  localparam int unsigned DIGIT_W  = 4;

  // Op queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    OP_START,
    OP_CHAR,
    OP_END
  } op_kind_e;

  typedef enum logic [2:0] {
    CLS_BLANK,
    CLS_PLUS,
    CLS_MINUS,
    CLS_POINT,
    CLS_DIGIT,
    CLS_OTHER
  } char_cls_e;

  typedef struct packed {
    op_kind_e            kind;
    char_cls_e           cls;
    logic [DIGIT_W-1:0]  digit;
    logic                hdr_neg;
  } op_t;

endpackage

`default_nettype wire

// ===== rtl/sfwd_if.sv =====
// Interfaces: byte request channel and weight result channel.
`default_nettype none

interface sfwd_rx_if;
  import sfwd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfwd_res_if;
  import sfwd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [WEIGHT_W-1:0] weight_value;
  logic [FRAC_W-1:0]          fraction_digits;
  logic                       parse_ok;

  modport source (output valid, output weight_value, output fraction_digits,
                  output parse_ok, input ready);
  modport sink   (input valid, input weight_value, input fraction_digits,
                  input parse_ok, output ready);
endinterface

`default_nettype wire

// ===== rtl/sfwd_front.sv =====
// Front end: tracks frame position, classifies bytes, issues parse ops.
`default_nettype none

module sfwd_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  sfwd_rx_if.sink             rx_i,
  output sfwd_pkg::op_t       push_data_o,
  output logic                push_valid_o,
  input  wire logic           push_ready_i
);
  import sfwd_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(FIELD_START);
  localparam logic [POS_W-1:0] POS_AFTER = POS_W'(FIELD_START + FIELD_CHARS);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             accept;
  logic             in_field;
  char_cls_e        cls;

  always_comb begin
    if (rx_i.rx_byte >= CHAR_ZERO && rx_i.rx_byte <= CHAR_NINE) begin
      cls = CLS_DIGIT;
    end else if (rx_i.rx_byte == CHAR_SPACE ||
                 (rx_i.rx_byte >= CHAR_TAB && rx_i.rx_byte <= CHAR_CR)) begin
      cls = CLS_BLANK;
    end else if (rx_i.rx_byte == CHAR_PLUS) begin
      cls = CLS_PLUS;
    end else if (rx_i.rx_byte == CHAR_MINUS) begin
      cls = CLS_MINUS;
    end else if (rx_i.rx_byte == CHAR_POINT) begin
      cls = CLS_POINT;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign rx_i.ready = push_ready_i;
  assign accept     = rx_i.valid && push_ready_i;
  assign in_field   = (pos_q >= POS_FIRST) && (pos_q < POS_AFTER);

  always_comb begin
    push_data_o.cls     = cls;
    push_data_o.digit   = rx_i.rx_byte[DIGIT_W-1:0];
    push_data_o.hdr_neg = (rx_i.rx_byte == CHAR_MINUS);
    push_data_o.kind    = OP_CHAR;
    push_valid_o        = 1'b0;
    if (pos_q == '0) begin
      push_data_o.kind = OP_START;
      push_valid_o     = rx_i.valid;
    end else if (in_field) begin
      push_data_o.kind = OP_CHAR;
      push_valid_o     = rx_i.valid;
    end else if (pos_q == POS_LAST) begin
      push_data_o.kind = OP_END;
      push_valid_o     = rx_i.valid;
    end
  end

  // Last byte closes the frame; a line feed anywhere restarts it
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (pos_q == POS_LAST || rx_i.rx_byte == CHAR_LF) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfwd_queue.sv =====
// Short op queue between front and back end.
`default_nettype none

module sfwd_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sfwd_pkg::op_t  push_data_i,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  output sfwd_pkg::op_t       pop_data_o,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i
);
  import sfwd_pkg::*;

  op_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic                do_push, do_pop;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
  endfunction

  assign push_ready_o = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QUEUE_CW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfwd_back.sv =====
// Back end: decimal field parser and result register.
`default_nettype none

module sfwd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sfwd_pkg::op_t  pop_data_i,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  sfwd_res_if.source          res_o
);
  import sfwd_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_BODY,
    PH_DONE
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  logic                point_q, point_d;
  logic                digit_q, digit_d;
  logic                fneg_q, fneg_d;
  logic                hneg_q, hneg_d;

  logic                       out_valid_q;
  logic signed [WEIGHT_W-1:0] out_weight_q;
  logic [FRAC_W-1:0]          out_frac_q;
  logic                       out_ok_q;

  logic                do_pop, do_end;
  logic [WEIGHT_W-1:0] mag, weight;

  assign pop_ready_o = (pop_data_i.kind != OP_END) || !out_valid_q || res_o.ready;
  assign do_pop      = pop_valid_i && pop_ready_o;
  assign do_end      = do_pop && (pop_data_i.kind == OP_END);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    point_d = point_q;
    digit_d = digit_q;
    fneg_d  = fneg_q;
    hneg_d  = hneg_q;
    if (do_pop) begin
      case (pop_data_i.kind)
        OP_START: begin
          phase_d = PH_LEAD;
          acc_d   = '0;
          frac_d  = '0;
          point_d = 1'b0;
          digit_d = 1'b0;
          fneg_d  = 1'b0;
          hneg_d  = pop_data_i.hdr_neg;
        end
        OP_CHAR: begin
          if (phase_q == PH_LEAD && pop_data_i.cls == CLS_BLANK) begin
            // skip leading whitespace
          end else if (phase_q == PH_LEAD &&
                       (pop_data_i.cls == CLS_PLUS || pop_data_i.cls == CLS_MINUS)) begin
            fneg_d  = (pop_data_i.cls == CLS_MINUS);
            phase_d = PH_BODY;
          end else if (phase_q != PH_DONE) begin
            phase_d = PH_BODY;
            if (pop_data_i.cls == CLS_DIGIT) begin
              // acc * 10 + digit, kept to accumulator width
              acc_d   = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0}
                        + ACC_W'(pop_data_i.digit);
              digit_d = 1'b1;
              if (point_q) begin
                frac_d = frac_q + FRAC_W'(1);
              end
            end else if (pop_data_i.cls == CLS_POINT && !point_q) begin
              point_d = 1'b1;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign mag    = {1'b0, acc_q};
  assign weight = (hneg_q ^ fneg_q) ? (~mag + WEIGHT_W'(1)) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_LEAD;
      acc_q        <= '0;
      frac_q       <= '0;
      point_q      <= 1'b0;
      digit_q      <= 1'b0;
      fneg_q       <= 1'b0;
      hneg_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_weight_q <= '0;
      out_frac_q   <= '0;
      out_ok_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      point_q <= point_d;
      digit_q <= digit_d;
      fneg_q  <= fneg_d;
      hneg_q  <= hneg_d;
      if (do_end) begin
        out_valid_q  <= 1'b1;
        out_weight_q <= digit_q ? $signed(weight) : '0;
        out_frac_q   <= digit_q ? frac_q : '0;
        out_ok_q     <= digit_q;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.weight_value    = out_weight_q;
  assign res_o.fraction_digits = out_frac_q;
  assign res_o.parse_ok        = out_ok_q;

endmodule

`default_nettype wire

// ===== rtl/scale_frame_weight_decoder.sv =====
// Top level: scale report frame decoder producing a signed decimal weight.
//
//  channel  dir  request fields                               accepted when
//  -------  ---  -------------------------------------------  -------------------
//  rx_i     in   rx_byte[7:0]                                 valid && ready
//  res_o    out  weight_value[24:0] s, fraction_digits[2:0],  valid && ready
//                parse_ok
//
//  One byte is taken every cycle; the front end only stalls when the
//  two-entry op queue is full. That needs a finished result waiting in the
//  output register, the next frame end stuck behind it at the queue head,
//  and the first byte of the frame after that queued as well.
//  A frame's last op is registered in the op queue, and its result then
//  in the parser's output register.
//  Reset (rst_ni low, asynchronous) clears frame position, parse state,
//  queue and output valid; no clearing pass is needed.
`default_nettype none

module scale_frame_weight_decoder (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sfwd_rx_if.sink      rx_i,
  sfwd_res_if.source   res_o
);
  import sfwd_pkg::*;

  // front -> queue
  op_t  push_data;
  logic push_valid;
  logic push_ready;

  // queue -> back
  op_t  pop_data;
  logic pop_valid;
  logic pop_ready;

  // Front: byte position tracking and character classification
  sfwd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .push_data_o  (push_data),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // Decouples byte intake from the result handshake
  sfwd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_data),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  // Back: incremental decimal parse, sign fold and result register
  sfwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the scale frame weight decoder: directed and random report frames.
`timescale 1ns / 100ps

module tb;
  import sfwd_pkg::*;

  // Whitespace codes the package does not name
  localparam logic [BYTE_W-1:0] CHAR_VT = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF = 8'h0C;

  // Unit and terminator bytes used by the directed reports (space, g, space, CR, LF)
  localparam string REPORT_TAIL = " g \015\n";

  // A result passes the op queue and the output register after the last byte; allow generous slack
  localparam int DRAIN_CYCLES   = 8;
  // Longest legal quiet stretch comes from the long output hold
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;

  typedef enum logic [1:0] {
    LEAD_WS,
    IN_NUMBER,
    STOPPED
  } num_phase_e;

  typedef struct {
    logic signed [WEIGHT_W-1:0] value;
    logic [FRAC_W-1:0]          frac;
    logic                       ok;
  } weight_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  sfwd_rx_if  rx_ch ();
  sfwd_res_if res_ch ();

  scale_frame_weight_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  // ---------------------------------------------------------------------------
  // Frame tracker: mirrors the decoder's frame position and the incremental
  // parse of the decimal field, and queues the weight each complete frame
  // must produce.
  // ---------------------------------------------------------------------------
  logic [3:0]         frame_pos;
  logic               hdr_minus;
  num_phase_e         num_phase;
  logic [ACC_W-1:0]   digit_acc;
  logic [FRAC_W-1:0]  frac_digits;
  logic               point_found;
  logic               digit_found;
  logic               field_minus;

  weight_t expected_weights[$];

  // Idling knobs; written by the tests at rising edges only
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  // Run statistics
  int mismatches    = 0;
  int bytes_taken   = 0;
  int weights_seen  = 0;
  int nan_seen      = 0;
  int neg_seen      = 0;
  int quiet_cycles  = 0;

  function automatic void parse_field_char(input logic [BYTE_W-1:0] c);
    logic is_digit;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    if (num_phase == STOPPED) return;
    if (num_phase == LEAD_WS) begin
      // space plus TAB..CR are skipped before the number
      if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) return;
      if (c == CHAR_PLUS || c == CHAR_MINUS) begin
        field_minus = (c == CHAR_MINUS);
        num_phase   = IN_NUMBER;
        return;
      end
      num_phase = IN_NUMBER;
    end
    if (is_digit) begin
      digit_acc   = digit_acc * 10 + (c - CHAR_ZERO);
      digit_found = 1'b1;
      if (point_found) frac_digits = frac_digits + 1'b1;
    end else if (c == CHAR_POINT && !point_found) begin
      point_found = 1'b1;
    end else begin
      // anything else, a second point included, ends the number
      num_phase = STOPPED;
    end
  endfunction

  function automatic void track_byte(input logic [BYTE_W-1:0] c);
    logic [3:0]          pos;
    logic [WEIGHT_W-1:0] mag;
    weight_t             w;
    pos = frame_pos;
    if (pos == 0) begin
      num_phase   = LEAD_WS;
      digit_acc   = '0;
      frac_digits = '0;
      point_found = 1'b0;
      digit_found = 1'b0;
      field_minus = 1'b0;
      hdr_minus   = (c == CHAR_MINUS);
    end else if (pos >= FIELD_START && pos < FIELD_START + FIELD_CHARS) begin
      parse_field_char(c);
    end
    pos = pos + 1'b1;
    if (pos == FRAME_BYTES) begin
      w.value = '0;
      w.frac  = '0;
      w.ok    = 1'b0;
      if (digit_found) begin
        mag = {1'b0, digit_acc};
        // header sign and field sign cancel each other; minus zero stays zero
        if (hdr_minus ^ field_minus) mag = -mag;
        w.value = mag;
        w.frac  = frac_digits;
        w.ok    = 1'b1;
      end
      expected_weights.push_back(w);
      pos = 0;
    end
    // a line feed always restarts the frame, dropping a partial one
    if (c == CHAR_LF) pos = 0;
    frame_pos = pos;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: checks results first, then tracks the byte taken at the same
  // edge (a byte can never complete in the same cycle its result appears).
  // Also the watchdog: cycles with no request moving on either channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    weight_t want;
    logic    moved;
    if (rst_n) begin
      moved = 1'b0;
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        if (expected_weights.size() == 0) begin
          $error("weight result with nothing expected: weight_value %0d",
                 res_ch.weight_value);
          mismatches++;
        end else begin
          want = expected_weights.pop_front();
          weights_seen++;
          if (!want.ok) nan_seen++;
          if (want.value < 0) neg_seen++;
          if (res_ch.weight_value !== want.value) begin
            $error("weight_value: expected %0d, got %0d", want.value, res_ch.weight_value);
            mismatches++;
          end
          if (res_ch.fraction_digits !== want.frac) begin
            $error("fraction_digits: expected %0d, got %0d", want.frac,
                   res_ch.fraction_digits);
            mismatches++;
          end
          if (res_ch.parse_ok !== want.ok) begin
            $error("parse_ok: expected %0d, got %0d", want.ok, res_ch.parse_ok);
            mismatches++;
          end
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        moved = 1'b1;
        bytes_taken++;
        track_byte(rx_ch.rx_byte);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: %0d cycles without a request, %0d results outstanding",
                 quiet_cycles, expected_weights.size());
        $display("scale_frame_weight_decoder test failed");
        $finish;
      end
    end
  end

  // Result side: random stalls, or a counted long hold when a test asks for one
  initial begin : result_ready
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender. Called just after a falling edge; returns at the falling
  // edge after acceptance with valid still high, so a following byte can be
  // offered back to back. Anything that pauses first drops valid.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // two header bytes, seven field characters, fixed unit and line end
  task automatic send_report(input string hdr, input string field);
    send_text({hdr, field, REPORT_TAIL});
  endtask

  // changes idling at a rising edge so the ready process never races it
  task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    hold_left      = hold;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    rx_ch.valid <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_non_lf();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_LF);
    return b;
  endfunction

  // Mostly well-formed frames with random numbers; some raw noise and some
  // frames cut short by an early line feed.
  task automatic send_random_report();
    logic [BYTE_W-1:0] frame [FRAME_BYTES];
    int roll, lead, cut, n, p;
    roll = $urandom_range(99);
    if (roll < 8) begin
      n = $urandom_range(1, 20);
      repeat (n) send_byte(8'($urandom_range(255)));
      return;
    end
    cut = (roll < 15) ? $urandom_range(1, FRAME_BYTES - 2) : FRAME_BYTES;

    frame[0] = ($urandom_range(99) < 35) ? CHAR_MINUS : pick_non_lf();
    frame[1] = pick_non_lf();
    lead = ($urandom_range(3) == 0) ? $urandom_range(FIELD_CHARS) : $urandom_range(2);
    for (int i = 0; i < FIELD_CHARS; i++) begin
      p = FIELD_START + i;
      if (i < lead) begin
        case ($urandom_range(4))
          0:       frame[p] = CHAR_TAB;
          1:       frame[p] = CHAR_VT;
          2:       frame[p] = CHAR_FF;
          3:       frame[p] = CHAR_CR;
          default: frame[p] = CHAR_SPACE;
        endcase
      end else if (i == lead && $urandom_range(1)) begin
        frame[p] = $urandom_range(1) ? CHAR_MINUS : CHAR_PLUS;
      end else begin
        n = $urandom_range(99);
        if (n < 78)      frame[p] = CHAR_ZERO + 8'($urandom_range(9));
        else if (n < 88) frame[p] = CHAR_POINT;
        else             frame[p] = pick_non_lf();
      end
    end
    for (int i = FIELD_START + FIELD_CHARS; i < FRAME_BYTES - 1; i++) frame[i] = pick_non_lf();
    frame[FRAME_BYTES-1] = ($urandom_range(99) < 85) ? CHAR_LF : pick_non_lf();

    for (int i = 0; i < cut; i++) send_byte(frame[i]);
    if (cut < FRAME_BYTES) send_byte(CHAR_LF);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_reports();
    logic [BYTE_W-1:0] raw [FRAME_BYTES] = '{8'hFF, 8'h00, 8'h33, 8'hFF, 8'h00, 8'h00,
                                             8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00,
                                             8'h00, 8'hFF};
    set_idling(0, 0, 0);
    send_report("ST", "  +12.3");          // plain positive with a fraction
    send_report("-T", "9999999");          // header minus, largest magnitude
    send_report("ST", "-0.0000");          // minus zero
    send_report("--", "  -42.5");          // both signs cancel
    send_report("ST", "       ");          // all blanks: not a number
    send_report("ST", "   +   ");          // lone sign
    send_report("US", "   .   ");          // lone point
    send_report("ST", " 1.2.3 ");          // second point stops the parse
    send_report("ST", "\t\013\014\015 7 "); // every whitespace code but LF before a digit
    send_report("ST", ".000001");          // most fraction digits the field holds
    send_report("ST", "12a34  ");          // junk ends the number
    send_report("ST", "-+5    ");          // sign after sign: not a number
    send_text("ST 12\n");                  // early line feed drops the frame
    send_report("ST", "  0.5  ");
    send_text("ST   100 g ABC");           // last byte need not be a line feed
    foreach (raw[i]) send_byte(raw[i]);    // extreme byte values in every slot but one, a digit
    wait_for_results();
  endtask

  task automatic test_random_reports(input int send_pct, input int recv_pct,
                                     input int frames);
    set_idling(send_pct, recv_pct, 0);
    repeat (frames) send_random_report();
    wait_for_results();
  endtask

  // Result side holds off while bytes keep coming: the op queue and output
  // register fill and the byte input must stall without losing anything.
  task automatic test_output_stall();
    set_idling(0, 0, LONG_HOLD);
    repeat (6) send_random_report();
    wait_for_results();
  endtask

  initial begin : run
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    frame_pos     = '0;
    hdr_minus     = 1'b0;
    num_phase     = LEAD_WS;
    digit_acc     = '0;
    frac_digits   = '0;
    point_found   = 1'b0;
    digit_found   = 1'b0;
    field_minus   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_reports();
    test_random_reports(0, 0, 10);
    test_random_reports(55, 0, 10);
    test_random_reports(0, 55, 10);
    test_random_reports(26, 26, 10);
    test_output_stall();

    $display("Covered %0d bytes and %0d weight reports (%0d not a number, %0d negative),",
             bytes_taken, weights_seen, nan_seen, neg_seen);
    $display("across four idling mixes and a %0d-cycle result hold.", LONG_HOLD);
    if (mismatches == 0) begin
      $display("scale_frame_weight_decoder test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("scale_frame_weight_decoder test failed");
    end
    $finish;
  end

endmodule

// ===== scale_frame_weight_decoder.f =====
rtl/sfwd_pkg.sv
rtl/sfwd_if.sv
rtl/sfwd_front.sv
rtl/sfwd_queue.sv
rtl/sfwd_back.sv
rtl/scale_frame_weight_decoder.sv
tb/tb.sv
